// File: rtl/cbm_pkg.sv
`default_nettype none
package cbm_pkg;

    localparam int CHR_SLOTS = 8;

    typedef enum logic [1:0] {
        MODE_CPU_WR = 2'd0,
        MODE_CPU_RD = 2'd1,
        MODE_PPU    = 2'd2,
        MODE_TICK   = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        CMD_CHR0     = 4'h0,
        CMD_CHR1     = 4'h1,
        CMD_CHR2     = 4'h2,
        CMD_CHR3     = 4'h3,
        CMD_CHR4     = 4'h4,
        CMD_CHR5     = 4'h5,
        CMD_CHR6     = 4'h6,
        CMD_CHR7     = 4'h7,
        CMD_LOW_WIN  = 4'h8,
        CMD_PRG0     = 4'h9,
        CMD_PRG1     = 4'hA,
        CMD_PRG2     = 4'hB,
        CMD_MIRROR   = 4'hC,
        CMD_IRQ_CTRL = 4'hD,
        CMD_CNT_LO   = 4'hE,
        CMD_CNT_HI   = 4'hF
    } t_cmd;

    typedef enum logic {
        REG_PRG_MASK = 1'b0,
        REG_CHR_MASK = 1'b1
    } t_reg_idx;

    localparam logic [5:0]  PRG_MASK_RESET = 6'h3F;
    localparam logic [7:0]  CHR_MASK_RESET = 8'hFF;
    localparam logic [15:0] CNT_RELOAD     = 16'hFFFF;

    typedef struct packed {
        logic [5:0] prg_mask;
        logic [7:0] chr_mask;
    } t_cfg;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] address;
        logic [7:0]  data;
    } t_item;

    typedef struct packed {
        logic [18:0] prg_rom_offset;
        logic        prg_rom_select;
        logic        prg_ram_select;
        logic [12:0] prg_ram_offset;
        logic [17:0] chr_offset;
        logic [1:0]  mirror_mode;
        logic        irq_line;
    } t_result;

endpackage
`default_nettype wire

// File: rtl/cbm_cfg.sv
`default_nettype none
module cbm_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cbm_pkg::t_cfg      o_cfg
);

    logic [5:0] r_prg_mask;
    logic [7:0] r_chr_mask;
    logic       wr_en;
    cbm_pkg::t_reg_idx reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = cbm_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_mask <= cbm_pkg::PRG_MASK_RESET;
            r_chr_mask <= cbm_pkg::CHR_MASK_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                cbm_pkg::REG_PRG_MASK: r_prg_mask <= pwdata[5:0];
                cbm_pkg::REG_CHR_MASK: r_chr_mask <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            cbm_pkg::REG_PRG_MASK: prdata = {26'd0, r_prg_mask};
            cbm_pkg::REG_CHR_MASK: prdata = {24'd0, r_chr_mask};
            default:               prdata = 32'd0;
        endcase
    end

    assign o_cfg.prg_mask = r_prg_mask;
    assign o_cfg.chr_mask = r_chr_mask;

endmodule
`default_nettype wire

// File: rtl/cbm_core.sv
`default_nettype none
module cbm_core #(
    parameter int PRG_BANK_BITS = 6
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  cbm_pkg::t_item       i_item,
    input  cbm_pkg::t_cfg        i_cfg,
    output cbm_pkg::t_result     o_result
);

    localparam logic [7:0] FIELD_MASK = 8'((1 << PRG_BANK_BITS) - 1);

    logic [3:0]               r_cmd, n_cmd;
    logic [7:0]               r_chr_bank [cbm_pkg::CHR_SLOTS];
    logic [7:0]               n_chr_bank [cbm_pkg::CHR_SLOTS];
    logic [7:0]               r_low_win, n_low_win;
    logic [PRG_BANK_BITS-1:0] r_prg_bank [3];
    logic [PRG_BANK_BITS-1:0] n_prg_bank [3];
    logic [1:0]               r_mirror, n_mirror;
    logic                     r_irq_en, n_irq_en;
    logic                     r_cnt_en, n_cnt_en;
    logic [15:0]              r_counter, n_counter;
    logic                     r_irq_pend, n_irq_pend;

    logic [7:0]               prg_lim;
    logic [7:0]               rom_bank;
    logic [PRG_BANK_BITS-1:0] prg_param;
    logic [12:0]              chr_addr;
    logic [7:0]               chr_bank;
    cbm_pkg::t_result         res;

    assign prg_lim   = FIELD_MASK & 8'h3F & {2'b00, i_cfg.prg_mask};
    assign prg_param = PRG_BANK_BITS'(i_item.data & 8'h3F & FIELD_MASK);
    assign chr_addr  = i_item.address[12:0];
    assign chr_bank  = r_chr_bank[chr_addr[12:10]] & i_cfg.chr_mask;

    always_comb begin
        n_cmd      = r_cmd;
        n_chr_bank = r_chr_bank;
        n_low_win  = r_low_win;
        n_prg_bank = r_prg_bank;
        n_mirror   = r_mirror;
        n_irq_en   = r_irq_en;
        n_cnt_en   = r_cnt_en;
        n_counter  = r_counter;
        n_irq_pend = r_irq_pend;
        rom_bank   = 8'd0;
        res        = '0;

        case (i_item.mode)
            cbm_pkg::MODE_CPU_WR, cbm_pkg::MODE_CPU_RD: begin
                if (i_item.address[15:13] == 3'b011) begin
                    if (!r_low_win[6]) begin
                        if (i_item.mode == cbm_pkg::MODE_CPU_RD) begin
                            rom_bank           = {2'b00, r_low_win[5:0]};
                            res.prg_rom_select = 1'b1;
                        end
                    end else if (r_low_win[7]) begin
                        res.prg_ram_select = 1'b1;
                        res.prg_ram_offset = i_item.address[12:0];
                    end
                end else if (i_item.address[15]) begin
                    if (i_item.mode == cbm_pkg::MODE_CPU_RD) begin
                        case (i_item.address[14:13])
                            2'd0:    rom_bank = 8'(r_prg_bank[0]);
                            2'd1:    rom_bank = 8'(r_prg_bank[1]);
                            2'd2:    rom_bank = 8'(r_prg_bank[2]);
                            default: rom_bank = {2'b00, i_cfg.prg_mask};
                        endcase
                        res.prg_rom_select = 1'b1;
                    end else if (i_item.address[14:13] == 2'd0) begin
                        n_cmd = i_item.data[3:0];
                    end else if (i_item.address[14:13] == 2'd1) begin
                        case (cbm_pkg::t_cmd'(r_cmd)) inside
                            cbm_pkg::CMD_CHR0, cbm_pkg::CMD_CHR1, cbm_pkg::CMD_CHR2,
                            cbm_pkg::CMD_CHR3, cbm_pkg::CMD_CHR4, cbm_pkg::CMD_CHR5,
                            cbm_pkg::CMD_CHR6, cbm_pkg::CMD_CHR7:
                                n_chr_bank[r_cmd[2:0]] = i_item.data;
                            cbm_pkg::CMD_LOW_WIN: n_low_win     = i_item.data;
                            cbm_pkg::CMD_PRG0:    n_prg_bank[0] = prg_param;
                            cbm_pkg::CMD_PRG1:    n_prg_bank[1] = prg_param;
                            cbm_pkg::CMD_PRG2:    n_prg_bank[2] = prg_param;
                            cbm_pkg::CMD_MIRROR:  n_mirror      = i_item.data[1:0];
                            cbm_pkg::CMD_IRQ_CTRL: begin
                                n_irq_pend = 1'b0;
                                n_irq_en   = i_item.data[0];
                                n_cnt_en   = i_item.data[7];
                            end
                            cbm_pkg::CMD_CNT_LO:  n_counter = {r_counter[15:8], i_item.data};
                            default:              n_counter = {i_item.data, r_counter[7:0]};
                        endcase
                    end
                end
            end
            cbm_pkg::MODE_PPU: begin
                res.chr_offset = {chr_bank, chr_addr[9:0]};
            end
            default: begin
                if (r_cnt_en) begin
                    n_counter = r_counter - 16'd1;
                    if (r_irq_en && (r_counter <= 16'd1)) begin
                        n_irq_pend = 1'b1;
                        n_counter  = cbm_pkg::CNT_RELOAD;
                    end
                end
            end
        endcase

        if (res.prg_rom_select) begin
            res.prg_rom_offset = {(rom_bank[5:0] & prg_lim[5:0]), i_item.address[12:0]};
        end
        res.mirror_mode = n_mirror;
        res.irq_line    = n_irq_pend;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd      <= '0;
            r_chr_bank <= '{default: '0};
            r_low_win  <= '0;
            r_prg_bank <= '{default: '0};
            r_mirror   <= '0;
            r_irq_en   <= 1'b0;
            r_cnt_en   <= 1'b0;
            r_counter  <= '0;
            r_irq_pend <= 1'b0;
        end else if (i_fire) begin
            r_cmd      <= n_cmd;
            r_chr_bank <= n_chr_bank;
            r_low_win  <= n_low_win;
            r_prg_bank <= n_prg_bank;
            r_mirror   <= n_mirror;
            r_irq_en   <= n_irq_en;
            r_cnt_en   <= n_cnt_en;
            r_counter  <= n_counter;
            r_irq_pend <= n_irq_pend;
        end
    end

endmodule
`default_nettype wire

// File: rtl/cartridge_bank_mapper_irq.sv
// a result reaches the output through the input register and then the result register
// throughput: one beat per cycle if not stalled; the two registers keep both sides moving
// output stall backs up through the result register into the input register
// reset (synchronous, active low) clears both pipeline valids, all mapper state and
// the irq counter, and sets the bank masks to all ones
`default_nettype none
module cartridge_bank_mapper_irq #(
    parameter int PRG_BANK_BITS = 6
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [18:0]      o_prg_rom_offset,
    output logic             o_prg_rom_select,
    output logic             o_prg_ram_select,
    output logic [12:0]      o_prg_ram_offset,
    output logic [17:0]      o_chr_offset,
    output logic [1:0]       o_mirror_mode,
    output logic             o_irq_line,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic             r_in_valid;
    cbm_pkg::t_item   r_item;
    logic             r_out_valid;
    cbm_pkg::t_result r_out;
    cbm_pkg::t_result result;
    cbm_pkg::t_cfg    cfg;
    logic             fire;
    logic             in_take;

    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.mode    <= cbm_pkg::t_mode'(i_mode);
            r_item.address <= i_address;
            r_item.data    <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    cbm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cbm_core #(
        .PRG_BANK_BITS (PRG_BANK_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign o_out_valid      = r_out_valid;
    assign o_prg_rom_offset = r_out.prg_rom_offset;
    assign o_prg_rom_select = r_out.prg_rom_select;
    assign o_prg_ram_select = r_out.prg_ram_select;
    assign o_prg_ram_offset = r_out.prg_ram_offset;
    assign o_chr_offset     = r_out.chr_offset;
    assign o_mirror_mode    = r_out.mirror_mode;
    assign o_irq_line       = r_out.irq_line;

endmodule
`default_nettype wire

// File: tb/cbm_checker.sv
`default_nettype none
module cbm_checker
    import cbm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_data,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  t_result          i_result,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic        i_pready,
    output int               o_fail_count,
    output int               o_pending
);

    logic [5:0]  prg_mask;
    logic [7:0]  chr_mask;
    logic [3:0]  cmd_latch;
    logic [7:0]  chr_bank [CHR_SLOTS];
    logic [7:0]  window_bank;
    logic [5:0]  prg_bank [3];
    logic [1:0]  mirror;
    logic        irq_en;
    logic        cnt_en;
    logic        irq_pend;
    logic [15:0] counter;

    t_result map_results_q[$];
    int      fail_total = 0;

    function automatic logic [18:0] rom_offset(logic [5:0] bank, logic [15:0] addr);
        return {bank & prg_mask, addr[12:0]};
    endfunction

    // advances the mapper state by one beat and returns the translation it yields
    function automatic t_result map_access(t_mode mode, logic [15:0] addr, logic [7:0] data);
        t_result     res;
        logic [12:0] pa;
        logic [15:0] old;
        res = '0;
        case (mode)
            MODE_CPU_WR, MODE_CPU_RD: begin
                if (addr >= 16'h6000 && addr < 16'h8000) begin
                    if (!window_bank[6]) begin
                        if (mode == MODE_CPU_RD) begin
                            res.prg_rom_select = 1'b1;
                            res.prg_rom_offset = rom_offset(window_bank[5:0], addr);
                        end
                    end else if (window_bank[7]) begin
                        res.prg_ram_select = 1'b1;
                        res.prg_ram_offset = addr[12:0];
                    end
                end else if (addr >= 16'h8000) begin
                    if (mode == MODE_CPU_RD) begin
                        res.prg_rom_select = 1'b1;
                        res.prg_rom_offset = rom_offset(
                            (addr[14:13] == 2'd3) ? prg_mask : prg_bank[addr[14:13]], addr);
                    end else if (addr < 16'hA000) begin
                        cmd_latch = data[3:0];
                    end else if (addr < 16'hC000) begin
                        case (t_cmd'(cmd_latch))
                            CMD_LOW_WIN:  window_bank = data;
                            CMD_PRG0, CMD_PRG1, CMD_PRG2:
                                prg_bank[2'(cmd_latch - CMD_PRG0)] = data[5:0];
                            CMD_MIRROR:   mirror = data[1:0];
                            CMD_IRQ_CTRL: begin
                                irq_pend = 1'b0;
                                irq_en   = data[0];
                                cnt_en   = data[7];
                            end
                            CMD_CNT_LO:   counter[7:0] = data;
                            CMD_CNT_HI:   counter[15:8] = data;
                            default:      chr_bank[cmd_latch[2:0]] = data;
                        endcase
                    end
                end
            end
            MODE_PPU: begin
                pa = addr[12:0];
                res.chr_offset = {chr_bank[pa[12:10]] & chr_mask, pa[9:0]};
            end
            default: begin
                if (cnt_en) begin
                    old     = counter;
                    counter = old - 16'd1;
                    if (irq_en && old <= 16'd1) begin
                        irq_pend = 1'b1;
                        counter  = CNT_RELOAD;
                    end
                end
            end
        endcase
        res.mirror_mode = mirror;
        res.irq_line    = irq_pend;
        return res;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            prg_mask    = PRG_MASK_RESET;
            chr_mask    = CHR_MASK_RESET;
            cmd_latch   = '0;
            window_bank = '0;
            mirror      = '0;
            irq_en      = 1'b0;
            cnt_en      = 1'b0;
            irq_pend    = 1'b0;
            counter     = '0;
            for (int k = 0; k < CHR_SLOTS; k++) chr_bank[k] = '0;
            for (int k = 0; k < 3; k++) prg_bank[k] = '0;
            map_results_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[2]))
                    REG_PRG_MASK: prg_mask = i_pwdata[5:0];
                    REG_CHR_MASK: chr_mask = i_pwdata[7:0];
                endcase
            end
            if (i_in_valid && !i_in_stall)
                map_results_q.push_back(map_access(t_mode'(i_mode), i_address, i_data));
            if (i_out_valid && !i_out_stall) begin
                if (map_results_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got %p", $time, i_result);
                    fail_total++;
                end else begin
                    want = map_results_q.pop_front();
                    check_field("prg_rom_offset", 32'(want.prg_rom_offset),
                                32'(i_result.prg_rom_offset));
                    check_field("prg_rom_select", 32'(want.prg_rom_select),
                                32'(i_result.prg_rom_select));
                    check_field("prg_ram_select", 32'(want.prg_ram_select),
                                32'(i_result.prg_ram_select));
                    check_field("prg_ram_offset", 32'(want.prg_ram_offset),
                                32'(i_result.prg_ram_offset));
                    check_field("chr_offset", 32'(want.chr_offset), 32'(i_result.chr_offset));
                    check_field("mirror_mode", 32'(want.mirror_mode),
                                32'(i_result.mirror_mode));
                    check_field("irq_line", 32'(want.irq_line), 32'(i_result.irq_line));
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= map_results_q.size();
    end

endmodule
`default_nettype wire

// File: tb/tb_cartridge_bank_mapper_irq.sv
`default_nettype none
module tb_cartridge_bank_mapper_irq;
    import cbm_pkg::*;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [1:0]  i_mode      = '0;
    logic [15:0] i_address   = '0;
    logic [7:0]  i_data      = '0;
    logic        i_out_stall = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [18:0] o_prg_rom_offset;
    logic        o_prg_rom_select;
    logic        o_prg_ram_select;
    logic [12:0] o_prg_ram_offset;
    logic [17:0] o_chr_offset;
    logic [1:0]  o_mirror_mode;
    logic        o_irq_line;
    logic [31:0] prdata;
    logic        pready;

    t_result dut_result;
    int      fail_count;
    int      pending;
    int      tx_idle_pct = 21;
    int      rx_idle_pct = 65;

    assign dut_result = {o_prg_rom_offset, o_prg_rom_select, o_prg_ram_select,
                         o_prg_ram_offset, o_chr_offset, o_mirror_mode, o_irq_line};

    cartridge_bank_mapper_irq u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_mode(i_mode), .i_address(i_address), .i_data(i_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_prg_rom_offset(o_prg_rom_offset), .o_prg_rom_select(o_prg_rom_select),
        .o_prg_ram_select(o_prg_ram_select), .o_prg_ram_offset(o_prg_ram_offset),
        .o_chr_offset(o_chr_offset), .o_mirror_mode(o_mirror_mode),
        .o_irq_line(o_irq_line),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    cbm_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_mode(i_mode), .i_address(i_address), .i_data(i_data),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_result(dut_result),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk)
        i_out_stall <= (rx_idle_pct > 0) && ($urandom_range(0, 99) < rx_idle_pct);

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_beat(t_mode mode, logic [15:0] addr, logic [7:0] data);
        while ((tx_idle_pct > 0) && ($urandom_range(0, 99) < tx_idle_pct)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_address  <= addr;
        i_data     <= data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(4 * idx);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_command(t_cmd cmd, logic [7:0] param);
        send_beat(MODE_CPU_WR, {3'b100, 13'($urandom)}, {4'($urandom), cmd});
        send_beat(MODE_CPU_WR, {3'b101, 13'($urandom)}, param);
    endtask

    task automatic run_random(int n);
        int          sent;
        int          pick;
        int          burst;
        t_cmd        cmd;
        logic [7:0]  param;
        logic [15:0] addr;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                cmd   = t_cmd'($urandom_range(0, 15));
                param = 8'($urandom);
                if (cmd == CMD_CNT_HI && $urandom_range(0, 9) < 7)
                    param = 8'h00;
                else if (cmd == CMD_CNT_LO && $urandom_range(0, 9) < 7)
                    param = 8'($urandom_range(0, 40));
                else if (cmd == CMD_IRQ_CTRL && $urandom_range(0, 9) < 6)
                    param = param | 8'h81;
                run_command(cmd, param);
                sent += 2;
            end else if (pick < 55) begin
                addr = $urandom_range(0, 1) ? {3'b011, 13'($urandom)} : 16'($urandom);
                send_beat(MODE_CPU_RD, addr, 8'($urandom));
                sent++;
            end else if (pick < 70) begin
                send_beat(MODE_PPU, 16'($urandom), 8'($urandom));
                sent++;
            end else if (pick < 88) begin
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst; k++)
                    send_beat(MODE_TICK, 16'($urandom), 8'($urandom));
                sent += burst;
            end else begin
                send_beat(t_mode'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
                sent++;
            end
        end
    endtask

    task automatic run_phase(int tx, int rx, logic [5:0] pm, logic [7:0] cm, int n,
                             bit hold_mid);
        drain();
        write_reg(REG_PRG_MASK, 32'(pm));
        write_reg(REG_CHR_MASK, 32'(cm));
        tx_idle_pct = tx;
        rx_idle_pct = rx;
        if (hold_mid) begin
            run_random(n / 2);
            drain();
            run_random(n - n / 2);
        end else begin
            run_random(n);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fixed last bank, undecoded space, default low window
        send_beat(MODE_CPU_RD, 16'hFFFF, 8'h00);
        send_beat(MODE_CPU_RD, 16'h5FFF, 8'hFF);
        send_beat(MODE_CPU_RD, 16'h6000, 8'h00);
        // low window as enabled ram
        run_command(CMD_LOW_WIN, 8'hC5);
        send_beat(MODE_CPU_RD, 16'h7FFF, 8'h00);
        send_beat(MODE_CPU_WR, 16'h6123, 8'h55);
        // ram selected but disabled maps nothing
        run_command(CMD_LOW_WIN, 8'h40);
        send_beat(MODE_CPU_RD, 16'h6000, 8'h00);
        send_beat(MODE_CPU_WR, 16'h7000, 8'hAA);
        // rom in the low window, then a write to rom
        run_command(CMD_LOW_WIN, 8'h3F);
        send_beat(MODE_CPU_RD, 16'h7ABC, 8'h00);
        send_beat(MODE_CPU_WR, 16'h7ABC, 8'h12);
        send_beat(MODE_CPU_WR, 16'hC000, 8'hFF);
        // chr bank and ppu address above the pattern range
        run_command(CMD_CHR0, 8'hFF);
        send_beat(MODE_PPU, 16'hFFFF, 8'hFF);
        run_command(CMD_MIRROR, 8'h03);
        // counter at zero wraps on the first tick, then irq is cleared
        run_command(CMD_IRQ_CTRL, 8'h81);
        send_beat(MODE_TICK, 16'h0000, 8'hFF);
        run_command(CMD_IRQ_CTRL, 8'h00);

        run_phase(21, 65, 6'h00, 8'h00, 240, 1'b0);
        run_phase(21, 65, 6'h3F, 8'hFF, 240, 1'b1);
        run_phase(65, 21, 6'h07, 8'h0F, 240, 1'b0);
        run_phase(65, 21, 6'($urandom), 8'($urandom), 240, 1'b0);
        run_phase(0, 0, 6'($urandom), 8'($urandom), 240, 1'b0);
        run_phase(0, 0, 6'h01, 8'h80, 240, 1'b0);

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
